>>> src/vtd_pkg.sv
`timescale 1ns / 1ps

package vtd_pkg;

  // table geometry; both sizes are powers of two
  localparam int MAX_VERTICES = 4096;
  localparam int TABLE_SLOTS  = 8192;
  localparam int INDEX_BITS   = 25;

  localparam int FIELD_BITS = 25;
  localparam int VID_BITS   = 12;
  localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
  localparam int CNT_BITS   = $clog2(MAX_VERTICES + 1);

  // hash mixing constants
  localparam logic [31:0] MIX_C_POS  = 32'h9E3779B1;
  localparam logic [31:0] MIX_C_TEX  = 32'h85EBCA77;
  localparam logic [31:0] MIX_C_NORM = 32'hC2B2AE3D;
  localparam logic [31:0] MIX_C_FIN  = 32'h2C1B3C6D;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    MIX_POS,
    MIX_TEX,
    MIX_NORM,
    MIX_FIN
  } mix_step_t;

  typedef struct packed {
    logic      en;
    mix_step_t step;
  } mix_ctrl_t;

  typedef struct packed {
    logic                  valid;
    logic [INDEX_BITS-1:0] pos_key;
    logic [INDEX_BITS-1:0] tex_key;
    logic [INDEX_BITS-1:0] norm_key;
    logic [VID_BITS-1:0]   vid;
  } slot_word_t;

  localparam int SLOT_WORD_BITS = $bits(slot_word_t);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_CMP,
    ST_REPLY
  } state_t;

endpackage

>>> src/vtd_ram.sv
`timescale 1ns / 1ps

module vtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/vtd_mix_unit.sv
`timescale 1ns / 1ps

module vtd_mix_unit (
  input  logic                           clk,
  input  vtd_pkg::mix_ctrl_t             ctrl,
  input  logic [vtd_pkg::INDEX_BITS-1:0] pos_key,
  input  logic [vtd_pkg::INDEX_BITS-1:0] tex_key,
  input  logic [vtd_pkg::INDEX_BITS-1:0] norm_key,
  output logic [vtd_pkg::SLOT_BITS-1:0]  home_slot
);

  import vtd_pkg::*;

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] mul_a;
  logic [31:0] mul_c;
  logic [31:0] prod;
  logic [31:0] fold;

  // one 32x32 multiplier, low half kept, shared by all four steps
  always_comb begin
    mul_a = 32'(pos_key);
    mul_c = MIX_C_POS;
    case (ctrl.step)
      MIX_POS: begin
        mul_a = 32'(pos_key);
        mul_c = MIX_C_POS;
      end
      MIX_TEX: begin
        mul_a = 32'(tex_key);
        mul_c = MIX_C_TEX;
      end
      MIX_NORM: begin
        mul_a = 32'(norm_key);
        mul_c = MIX_C_NORM;
      end
      MIX_FIN: begin
        mul_a = acc ^ (acc >> 15);
        mul_c = MIX_C_FIN;
      end
      default: begin
        mul_a = 32'(pos_key);
        mul_c = MIX_C_POS;
      end
    endcase
  end

  assign prod = mul_a * mul_c;

  always_comb begin
    case (ctrl.step)
      MIX_TEX, MIX_NORM: acc_next = acc ^ prod;
      default:           acc_next = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

  assign fold      = acc ^ (acc >> 13);
  assign home_slot = fold[SLOT_BITS-1:0];

endmodule

>>> src/vertex_triple_dedup_unit.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | word
// --------+-----------+--------------------+-------------------------------------------
// input   | in        | in_valid/in_stall  | opcode, pos_index, tex_index, norm_index
// output  | out       | out_valid/out_stall| vertex_id, is_new, table_full, out_*_index
//
// a lookup that the home slot decides runs through accept, 4 passes through the
// shared hash multiplier, one table read, one compare and one reply; each extra
// collision probe adds one more read on the single table read port
// a clear writes one table row per cycle over every slot, then replies
// after reset the same sweep runs over every slot with in_stall high
// a finished word waits in the output register; the next word is taken meanwhile

module vertex_triple_dedup_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  opcode,
  input  logic signed [vtd_pkg::FIELD_BITS-1:0] pos_index,
  input  logic signed [vtd_pkg::FIELD_BITS-1:0] tex_index,
  input  logic signed [vtd_pkg::FIELD_BITS-1:0] norm_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [vtd_pkg::VID_BITS-1:0]          vertex_id,
  output logic                                  is_new,
  output logic                                  table_full,
  output logic signed [vtd_pkg::FIELD_BITS-1:0] out_pos_index,
  output logic signed [vtd_pkg::FIELD_BITS-1:0] out_tex_index,
  output logic signed [vtd_pkg::FIELD_BITS-1:0] out_norm_index
);

  import vtd_pkg::*;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

  // sequencer state
  state_t              state, state_next;
  mix_step_t           step, step_next;
  logic [SLOT_BITS-1:0] slot, slot_next;
  logic [SLOT_BITS-1:0] probes, probes_next;
  logic [SLOT_BITS-1:0] sweep, sweep_next;
  logic [CNT_BITS-1:0]  next_vid, next_vid_next;
  logic                 clear_reply, clear_reply_next;

  // captured word and staged answer
  logic signed [FIELD_BITS-1:0] pos_q, pos_q_next;
  logic signed [FIELD_BITS-1:0] tex_q, tex_q_next;
  logic signed [FIELD_BITS-1:0] norm_q, norm_q_next;
  logic [VID_BITS-1:0]          res_vid, res_vid_next;
  logic                         res_new, res_new_next;
  logic                         res_full, res_full_next;

  // output register next values
  logic                         out_valid_next;
  logic [VID_BITS-1:0]          vertex_id_next;
  logic                         is_new_next;
  logic                         table_full_next;
  logic signed [FIELD_BITS-1:0] out_pos_next;
  logic signed [FIELD_BITS-1:0] out_tex_next;
  logic signed [FIELD_BITS-1:0] out_norm_next;

  // keys: each index cut to INDEX_BITS, no sign extension
  logic [INDEX_BITS-1:0] pos_key;
  logic [INDEX_BITS-1:0] tex_key;
  logic [INDEX_BITS-1:0] norm_key;

  mix_ctrl_t             mix_ctrl;
  logic [SLOT_BITS-1:0]  home_slot;

  logic                      ram_we;
  logic [SLOT_BITS-1:0]      ram_waddr;
  slot_word_t                ram_wword;
  logic                      ram_re;
  logic [SLOT_BITS-1:0]      ram_raddr;
  logic [SLOT_WORD_BITS-1:0] ram_rbits;
  slot_word_t                rd_word;

  logic [SLOT_BITS-1:0] slot_inc;
  logic                 key_match;
  logic                 out_free;

  assign pos_key  = INDEX_BITS'($unsigned(pos_q));
  assign tex_key  = INDEX_BITS'($unsigned(tex_q));
  assign norm_key = INDEX_BITS'($unsigned(norm_q));

  assign rd_word  = slot_word_t'(ram_rbits);
  assign slot_inc = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
  assign key_match = (rd_word.pos_key == pos_key) && (rd_word.tex_key == tex_key) &&
                     (rd_word.norm_key == norm_key);
  // output register can take a new word this cycle
  assign out_free = !out_valid || !out_stall;

  vtd_mix_unit u_mix (
    .clk       (clk),
    .ctrl      (mix_ctrl),
    .pos_key   (pos_key),
    .tex_key   (tex_key),
    .norm_key  (norm_key),
    .home_slot (home_slot)
  );

  // one row per slot: valid bit, the three keys and the assigned vertex number
  vtd_ram #(
    .WIDTH (SLOT_WORD_BITS),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wword),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      step        <= MIX_POS;
      sweep       <= '0;
      next_vid    <= '0;
      clear_reply <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      sweep       <= sweep_next;
      next_vid    <= next_vid_next;
      clear_reply <= clear_reply_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    slot           <= slot_next;
    probes         <= probes_next;
    pos_q          <= pos_q_next;
    tex_q          <= tex_q_next;
    norm_q         <= norm_q_next;
    res_vid        <= res_vid_next;
    res_new        <= res_new_next;
    res_full       <= res_full_next;
    vertex_id      <= vertex_id_next;
    is_new         <= is_new_next;
    table_full     <= table_full_next;
    out_pos_index  <= out_pos_next;
    out_tex_index  <= out_tex_next;
    out_norm_index <= out_norm_next;
  end

  always_comb begin
    state_next       = state;
    step_next        = step;
    slot_next        = slot;
    probes_next      = probes;
    sweep_next       = sweep;
    next_vid_next    = next_vid;
    clear_reply_next = clear_reply;
    pos_q_next       = pos_q;
    tex_q_next       = tex_q;
    norm_q_next      = norm_q;
    res_vid_next     = res_vid;
    res_new_next     = res_new;
    res_full_next    = res_full;

    // a taken word leaves the output register
    out_valid_next  = out_valid && out_stall;
    vertex_id_next  = vertex_id;
    is_new_next     = is_new;
    table_full_next = table_full;
    out_pos_next    = out_pos_index;
    out_tex_next    = out_tex_index;
    out_norm_next   = out_norm_index;

    in_stall      = 1'b1;
    mix_ctrl.en   = 1'b0;
    mix_ctrl.step = step;
    ram_we        = 1'b0;
    ram_waddr     = slot;
    ram_wword     = '0;
    ram_re        = 1'b0;
    ram_raddr     = slot;

    case (state)
      // write an empty row per cycle; after reset or on a clear word
      ST_SWEEP: begin
        ram_we     = 1'b1;
        ram_waddr  = sweep;
        ram_wword  = '0;
        sweep_next = sweep + 1'b1;
        if (sweep == LAST_SLOT) begin
          sweep_next = '0;
          state_next = clear_reply ? ST_REPLY : ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (opcode == OP_CLEAR) begin
            // clear answers with all fields zero once the sweep is done
            pos_q_next       = '0;
            tex_q_next       = '0;
            norm_q_next      = '0;
            res_vid_next     = '0;
            res_new_next     = 1'b0;
            res_full_next    = 1'b0;
            next_vid_next    = '0;
            clear_reply_next = 1'b1;
            sweep_next       = '0;
            state_next       = ST_SWEEP;
          end else begin
            pos_q_next       = pos_index;
            tex_q_next       = tex_index;
            norm_q_next      = norm_index;
            clear_reply_next = 1'b0;
            step_next        = MIX_POS;
            state_next       = ST_HASH;
          end
        end
      end

      // four passes through the shared multiplier
      ST_HASH: begin
        mix_ctrl.en = 1'b1;
        case (step)
          MIX_POS:  step_next = MIX_TEX;
          MIX_TEX:  step_next = MIX_NORM;
          MIX_NORM: step_next = MIX_FIN;
          default: begin
            step_next  = MIX_POS;
            state_next = ST_PROBE;
          end
        endcase
      end

      // read the home slot
      ST_PROBE: begin
        ram_re      = 1'b1;
        ram_raddr   = home_slot;
        slot_next   = home_slot;
        probes_next = '0;
        state_next  = ST_CMP;
      end

      // row of slot is on the read port
      ST_CMP: begin
        if (!rd_word.valid) begin
          if (next_vid < CNT_BITS'(MAX_VERTICES)) begin
            ram_we             = 1'b1;
            ram_waddr          = slot;
            ram_wword.valid    = 1'b1;
            ram_wword.pos_key  = pos_key;
            ram_wword.tex_key  = tex_key;
            ram_wword.norm_key = norm_key;
            ram_wword.vid      = VID_BITS'(next_vid);
            res_vid_next       = VID_BITS'(next_vid);
            res_new_next       = 1'b1;
            res_full_next      = 1'b0;
            next_vid_next      = next_vid + 1'b1;
          end else begin
            // vertex limit reached
            res_vid_next  = '0;
            res_new_next  = 1'b0;
            res_full_next = 1'b1;
          end
          state_next = ST_REPLY;
        end else if (key_match) begin
          res_vid_next  = rd_word.vid;
          res_new_next  = 1'b0;
          res_full_next = 1'b0;
          state_next    = ST_REPLY;
        end else if (probes == LAST_SLOT) begin
          // every slot visited without a match or a free row
          res_vid_next  = '0;
          res_new_next  = 1'b0;
          res_full_next = 1'b1;
          state_next    = ST_REPLY;
        end else begin
          // linear probe: read the next slot, wrapping at the end
          ram_re      = 1'b1;
          ram_raddr   = slot_inc;
          slot_next   = slot_inc;
          probes_next = probes + 1'b1;
        end
      end

      ST_REPLY: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          vertex_id_next   = res_vid;
          is_new_next      = res_new;
          table_full_next  = res_full;
          out_pos_next     = pos_q;
          out_tex_next     = tex_q;
          out_norm_next    = norm_q;
          clear_reply_next = 1'b0;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/vtd_checker.sv
`timescale 1ns / 1ps

module vtd_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  opcode,
  input logic signed [vtd_pkg::FIELD_BITS-1:0] pos_index,
  input logic signed [vtd_pkg::FIELD_BITS-1:0] tex_index,
  input logic signed [vtd_pkg::FIELD_BITS-1:0] norm_index,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [vtd_pkg::VID_BITS-1:0]          vertex_id,
  input logic                                  is_new,
  input logic                                  table_full,
  input logic signed [vtd_pkg::FIELD_BITS-1:0] out_pos_index,
  input logic signed [vtd_pkg::FIELD_BITS-1:0] out_tex_index,
  input logic signed [vtd_pkg::FIELD_BITS-1:0] out_norm_index
);

  import vtd_pkg::*;

  // a stalled word stays
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vertex_id) && $stable(is_new) && $stable(table_full))
    else $error("output word changed while stalled");

  // one word at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && table_full))
    else $error("new and full flagged together");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> vertex_id == '0)
    else $error("full answer carries a vertex number");

endmodule

bind vertex_triple_dedup_unit vtd_checker u_vtd_checker (.*);
